// ===== rtl/typed_message_stream_parser_macros.svh =====
// Assertion macros shared by the parser RTL.
`ifndef TYPED_MESSAGE_STREAM_PARSER_MACROS_SVH
`define TYPED_MESSAGE_STREAM_PARSER_MACROS_SVH
// Checks that an implication holds at every clock edge outside reset.
`define TMSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Checks an implication in the next cycle.
`define TMSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/tmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmsp_pkg
// Shared types, codes and helpers of the typed message stream parser.
// ----------------------------------------------------------------------------
`default_nettype none
package tmsp_pkg;
    localparam int MaxTokens = 3;
    localparam int QDepth    = 4;

    typedef enum logic [3:0] {
        K_HEADER = 4'd0, K_TYPE = 4'd1, K_CHR = 4'd2, K_INT = 4'd3, K_LON = 4'd4,
        K_TSTART = 4'd5, K_TBYTE = 4'd6, K_TEND = 4'd7, K_ASTART = 4'd8,
        K_MEND = 4'd9, K_UNKTAG = 4'd10, K_UNIMPL = 4'd11, K_BADELEM = 4'd12,
        K_BADLEN = 4'd13, K_COMPR = 4'd14, K_SPARE = 4'd15
    } t_kind;

    typedef enum logic [3:0] {
        P_HLEN, P_HCOMP, P_TAG, P_CHR, P_INT, P_LONLEN, P_LONTXT, P_STRLEN,
        P_TXT, P_SHORTLEN, P_ATAG, P_ACOUNT, P_AINT, P_SKIP, P_BAD14, P_BAD15
    } t_phase;

    localparam logic [3:0] T_CHR = 4'd0, T_INT = 4'd1, T_LON = 4'd2,
        T_STR = 4'd3, T_HTB = 4'd7, T_INL = 4'd10, T_ARR = 4'd11, ID_MARK = 4'd15;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [3:0]  type_code;
        logic [7:0]  aux_byte;
        logic        in_array;
        logic        is_identifier;
        logic        last;
    } t_token;

    // Tag lookup: returns index 0..11, or 15 when not a known tag.
    function automatic logic [3:0] tag_lookup(input logic [23:0] c);
        logic [3:0] r;
        r = 4'd15;
        unique case (c)
            24'h636872: r = 4'd0;
            24'h696e74: r = 4'd1;
            24'h6c6f6e: r = 4'd2;
            24'h737472: r = 4'd3;
            24'h627566: r = 4'd4;
            24'h707472: r = 4'd5;
            24'h74696d: r = 4'd6;
            24'h687462: r = 4'd7;
            24'h686461: r = 4'd8;
            24'h696e66: r = 4'd9;
            24'h696e6c: r = 4'd10;
            24'h617272: r = 4'd11;
            default:    r = 4'd15;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/typed_message_stream_parser.sv =====
// ----------------------------------------------------------------------------
// typed_message_stream_parser
// Byte-wide parser of typed length-prefixed messages that emits tokens.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | i_valid, o_ready, i_data_byte             | byte stream in
//  out     | o_valid, i_ready, o_kind .. o_last        | token stream out
//
// One byte is parsed per cycle; each byte yields zero to three tokens, which
// leave through a four-entry queue at one token per cycle while i_ready is
// high. Input stalls only when the queue lacks room for three more tokens,
// so with i_ready high it takes a byte per cycle until tokens outnumber bytes.
// Reset is synchronous and clears the parse state and the queue.
`default_nettype none
module typed_message_stream_parser
    import tmsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_data_byte,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [3:0]              o_kind,
    output logic signed [63:0]      o_value,
    output logic [3:0]              o_type_code,
    output logic [7:0]              o_aux_byte,
    output logic                    o_in_array,
    output logic                    o_is_identifier,
    output logic                    o_last
);
`include "typed_message_stream_parser_macros.svh"

    t_phase      r_phase, n_phase;
    logic [31:0] r_body, n_body, r_field, n_field, r_elem, n_elem;
    logic [63:0] r_acc, n_acc;
    logic [15:0] r_tag, n_tag;
    logic [3:0]  r_otype, n_otype, r_etype, n_etype, r_flags, n_flags;
    logic [7:0]  r_comp, n_comp;

    t_token      tok [MaxTokens];
    logic [1:0]  cnt;
    logic        acc_in, room;
    t_token      q_out;

    assign o_ready = room;
    assign acc_in  = i_valid && room;

    always_comb begin
        logic [7:0]  b;
        logic [31:0] g4, v, br;
        logic [2:0]  fr3;
        logic [3:0]  idx, ttype;
        logic        inarr, isid, done4, fin, chainb, chaine;
        logic [63:0] limit, d, res, thr;
        logic        dig;
        logic [31:0] need;
        logic [3:0]  bph;
        b = i_data_byte;
        n_phase = r_phase; n_body = r_body; n_field = r_field; n_elem = r_elem;
        n_acc = r_acc; n_tag = r_tag; n_otype = r_otype; n_etype = r_etype;
        n_flags = r_flags; n_comp = r_comp;
        cnt = 2'd0;
        for (int k = 0; k < MaxTokens; k++) tok[k] = '0;
        g4 = {r_acc[23:0], b};
        done4 = (r_field >= 32'd3);
        fr3 = 3'd0;
        idx = 4'd0; v = '0; limit = '0; d = '0; res = '0; thr = '0; dig = 1'b0;
        chainb = 1'b0; chaine = 1'b0; fin = 1'b0; need = '0; bph = 4'(P_TAG);
        isid = (r_otype == ID_MARK);
        inarr = r_flags[3];
        ttype = isid ? T_STR : (inarr ? r_etype : r_otype);
        br = r_body - 32'd1;

        if (r_phase == P_HLEN || (r_phase != P_HCOMP && r_body == '0)) begin
            if (r_phase != P_HLEN) begin
                n_flags = '0;
            end
            // A new header starts from a cleared accumulator.
            n_acc = (r_phase == P_HLEN) ? {32'd0, g4} : {56'd0, b};
            if ((r_phase == P_HLEN ? r_field : 32'd0) >= 32'd3) begin
                n_field = '0; n_phase = P_HCOMP;
            end else begin
                n_field = (r_phase == P_HLEN ? r_field : 32'd0) + 32'd1;
                n_phase = P_HLEN;
            end
        end else if (r_phase == P_HCOMP) begin
            n_comp = b;
            n_body = (r_acc[31:0] >= 32'd5) ? r_acc[31:0] - 32'd5 : 32'd0;
            tok[0] = '{kind: K_HEADER, value: {32'd0, r_acc[31:0]}, type_code: 4'd0,
                       aux_byte: b, in_array: 1'b0, is_identifier: 1'b0, last: 1'b0};
            cnt = 2'd1;
            n_acc = '0; n_field = '0;
            if (b != 8'd0) begin
                tok[1] = '{K_COMPR, {32'd0, n_body}, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
                cnt = 2'd2; n_flags = '0;
                n_phase = (n_body != '0) ? P_SKIP : P_HLEN;
            end else begin
                n_otype = ID_MARK; n_flags = '0;
                if (n_body < 32'd4) begin
                    tok[1] = '{K_BADLEN, {32'd0, n_body}, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
                    cnt = 2'd2; n_phase = (n_body != '0) ? P_SKIP : P_HLEN;
                end else n_phase = P_STRLEN;
            end
        end else begin
            n_body = br;
            unique case (r_phase)
                P_TAG, P_ATAG: begin
                    if (r_field < 32'd2) begin
                        n_tag = {r_tag[7:0], b}; n_field = r_field + 32'd1;
                    end else begin
                        n_field = '0;
                        idx = tag_lookup({r_tag, b});
                        if (idx == 4'd15) begin
                            tok[0] = '{K_UNKTAG, {32'd0, br}, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
                            cnt = 2'd1; fin = 1'b1;
                        end else if (r_phase == P_ATAG) begin
                            if (idx != T_INT && idx != T_STR) begin
                                tok[0] = '{K_BADELEM, {32'd0, br}, idx, 8'd0, 1'b0, 1'b0,
                                           1'b0};
                                cnt = 2'd1; fin = 1'b1;
                            end else begin
                                n_etype = idx; chainb = 1'b1; need = 32'd4;
                                bph = 4'(P_ACOUNT);
                            end
                        end else if (idx >= T_HTB && idx <= T_INL) begin
                            tok[0] = '{K_UNIMPL, {32'd0, br}, idx, 8'd0, 1'b0, 1'b0, 1'b0};
                            cnt = 2'd1; fin = 1'b1;
                        end else begin
                            n_otype = idx;
                            tok[0] = '{K_TYPE, 64'd0, idx, 8'd0, 1'b0, 1'b0, 1'b0};
                            cnt = 2'd1; chainb = 1'b1;
                            unique case (idx)
                                4'd0: begin need = 32'd1; bph = 4'(P_CHR); end
                                4'd1: begin need = 32'd4; bph = 4'(P_INT); end
                                4'd2: begin need = 32'd1; bph = 4'(P_LONLEN); end
                                4'd3, 4'd4: begin need = 32'd4; bph = 4'(P_STRLEN); end
                                4'd5, 4'd6: begin need = 32'd1; bph = 4'(P_SHORTLEN); end
                                default: begin need = 32'd3; bph = 4'(P_ATAG); end
                            endcase
                        end
                    end
                end
                P_CHR: begin
                    tok[0] = '{K_CHR, {56'd0, b}, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
                    cnt = 2'd1; chaine = 1'b1;
                end
                P_INT, P_AINT: begin
                    n_acc = {32'd0, g4}; n_field = r_field + 32'd1;
                    if (done4) begin
                        tok[0] = '{K_INT, {{32{g4[31]}}, g4}, T_INT, 8'd0,
                                   r_phase == P_AINT, 1'b0, 1'b0};
                        cnt = 2'd1; chaine = 1'b1;
                    end
                end
                P_LONLEN: begin
                    if (b[7] || {24'd0, b} > br) begin
                        tok[0] = '{K_BADLEN, {32'd0, br}, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
                        cnt = 2'd1; fin = 1'b1;
                    end else if (b == 8'd0) begin
                        tok[0] = '{K_LON, 64'd0, T_LON, 8'd0, 1'b0, 1'b0, 1'b0};
                        cnt = 2'd1; chaine = 1'b1;
                    end else begin
                        n_phase = P_LONTXT; n_field = {24'd0, b}; n_acc = '0; n_flags = '0;
                    end
                end
                P_LONTXT: begin
                    dig = (b >= 8'h30 && b <= 8'h39);
                    if (!r_flags[2]) begin
                        if (!r_flags[1] && (b == 8'h20 || (b >= 8'd9 && b <= 8'd13))) begin
                            n_flags = r_flags;
                        end else if (!r_flags[1] && b == 8'h2b) begin
                            n_flags[1] = 1'b1;
                        end else if (!r_flags[1] && b == 8'h2d) begin
                            n_flags[1] = 1'b1; n_flags[0] = 1'b1;
                        end else if (!dig) begin
                            n_flags[2] = 1'b1;
                        end else begin
                            n_flags[1] = 1'b1;
                            limit = r_flags[0] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
                            d = {60'd0, 4'(b - 8'h30)};
                            // Saturate when acc*10+d would exceed the limit. The largest
                            // accumulator that still fits is limit/10, one less for the
                            // digits above the limit's last digit.
                            thr = (b > (r_flags[0] ? 8'h38 : 8'h37)) ?
                                  64'h0CCCCCCCCCCCCCCB : 64'h0CCCCCCCCCCCCCCC;
                            if (r_acc > thr) n_acc = limit;
                            else n_acc = (r_acc << 3) + (r_acc << 1) + d;
                        end
                    end
                    n_field = r_field - 32'd1;
                    if (n_field == '0) begin
                        res = n_flags[0] ? (64'd0 - n_acc) : n_acc;
                        tok[0] = '{K_LON, res, T_LON, 8'd0, 1'b0, 1'b0, 1'b0};
                        cnt = 2'd1; n_flags = '0; chaine = 1'b1;
                    end
                end
                P_STRLEN, P_ACOUNT: begin
                    n_acc = {32'd0, g4}; n_field = r_field + 32'd1;
                    v = g4;
                    if (done4) begin
                        if (r_phase == P_ACOUNT) begin
                            if (v[31]) begin
                                tok[0] = '{K_BADLEN, {32'd0, br}, 4'd0, 8'd0, 1'b0, 1'b0,
                                           1'b0};
                                cnt = 2'd1; fin = 1'b1;
                            end else begin
                                tok[0] = '{K_ASTART, {32'd0, v}, r_etype, 8'd0, 1'b0, 1'b0,
                                           1'b0};
                                cnt = 2'd1;
                                if (v == '0) chaine = 1'b1;
                                else begin
                                    n_elem = v; n_flags[3] = 1'b1; chainb = 1'b1;
                                    need = 32'd4;
                                    bph = (r_etype == T_INT) ? 4'(P_AINT) : 4'(P_STRLEN);
                                end
                            end
                        end else if (v == 32'hFFFFFFFF) begin
                            tok[0] = '{K_TSTART, '1, ttype, 8'd0, inarr, isid, 1'b0};
                            tok[1] = '{K_TEND, 64'd0, ttype, 8'd0, inarr, isid, 1'b0};
                            cnt = 2'd2; chaine = 1'b1;
                        end else if (v[31] || v > br) begin
                            tok[0] = '{K_BADLEN, {32'd0, br}, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
                            cnt = 2'd1; fin = 1'b1;
                        end else begin
                            tok[0] = '{K_TSTART, {32'd0, v}, ttype, 8'd0, inarr, isid, 1'b0};
                            cnt = 2'd1;
                            if (v == '0) begin
                                tok[1] = '{K_TEND, 64'd0, ttype, 8'd0, inarr, isid, 1'b0};
                                cnt = 2'd2; chaine = 1'b1;
                            end else begin
                                n_phase = P_TXT; n_field = v;
                            end
                        end
                    end
                end
                P_SHORTLEN: begin
                    if (b[7] || {24'd0, b} > br) begin
                        tok[0] = '{K_BADLEN, {32'd0, br}, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
                        cnt = 2'd1; fin = 1'b1;
                    end else begin
                        tok[0] = '{K_TSTART, {56'd0, b}, ttype, 8'd0, inarr, isid, 1'b0};
                        cnt = 2'd1;
                        if (b == 8'd0) begin
                            tok[1] = '{K_TEND, 64'd0, ttype, 8'd0, inarr, isid, 1'b0};
                            cnt = 2'd2; chaine = 1'b1;
                        end else begin
                            n_phase = P_TXT; n_field = {24'd0, b};
                        end
                    end
                end
                P_TXT: begin
                    tok[0] = '{K_TBYTE, {56'd0, b}, ttype, 8'd0, inarr, isid, 1'b0};
                    cnt = 2'd1;
                    n_field = (r_field != '0) ? r_field - 32'd1 : '0;
                    if (n_field == '0) begin
                        tok[1] = '{K_TEND, 64'd0, ttype, 8'd0, inarr, isid, 1'b0};
                        cnt = 2'd2; chaine = 1'b1;
                    end
                end
                P_SKIP: begin
                    if (br == '0) begin
                        n_phase = P_HLEN; n_field = '0; n_acc = '0; n_flags = '0;
                    end
                end
                default: begin
                    n_phase = P_HLEN; n_field = '0; n_acc = '0; n_flags = '0;
                end
            endcase

            // End of an item: finish an array element or reach the boundary.
            if (chaine) begin
                if (n_flags[3]) begin
                    n_elem = r_elem - 32'd1;
                    if (n_elem == '0) n_flags[3] = 1'b0;
                    else begin
                        chainb = 1'b1; need = 32'd4;
                        bph = (r_etype == T_INT) ? 4'(P_AINT) : 4'(P_STRLEN);
                    end
                end
                if (!chainb) begin
                    if (br == '0) begin
                        tok[cnt] = '{K_MEND, 64'd0, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
                        cnt = cnt + 2'd1;
                        n_phase = P_HLEN; n_field = '0; n_acc = '0; n_flags = '0;
                    end else begin
                        chainb = 1'b1; need = 32'd3; bph = 4'(P_TAG);
                    end
                end
            end
            if (chainb) begin
                if (br < need) begin
                    tok[cnt] = '{K_BADLEN, {32'd0, br}, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0};
                    cnt = cnt + 2'd1; fin = 1'b1;
                end else begin
                    n_phase = t_phase'(bph); n_field = '0; n_acc = '0;
                end
            end
            if (fin) begin
                n_field = '0; n_acc = '0; n_flags = '0;
                n_phase = (br != '0) ? P_SKIP : P_HLEN;
            end
        end
        fr3 = 3'(cnt);
        if (cnt != 2'd0) tok[cnt - 2'd1].last = 1'b1;
        if (fr3 == 3'd7) cnt = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_HLEN; r_body <= '0; r_field <= '0; r_acc <= '0; r_tag <= '0;
            r_otype <= '0; r_etype <= '0; r_elem <= '0; r_flags <= '0; r_comp <= '0;
        end else if (acc_in) begin
            r_phase <= n_phase; r_body <= n_body; r_field <= n_field; r_acc <= n_acc;
            r_tag <= n_tag; r_otype <= n_otype; r_etype <= n_etype; r_elem <= n_elem;
            r_flags <= n_flags; r_comp <= n_comp;
        end
    end

    tmsp_out_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (acc_in ? cnt : 2'd0),
        .i_tok        (tok),
        .o_room       (room),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tok        (q_out)
    );

    assign o_kind          = q_out.kind;
    assign o_value         = q_out.value;
    assign o_type_code     = q_out.type_code;
    assign o_aux_byte      = q_out.aux_byte;
    assign o_in_array      = q_out.in_array;
    assign o_is_identifier = q_out.is_identifier;
    assign o_last          = q_out.last;

    `TMSP_ASSERT_IMPL(a_skip_has_body, i_clk, i_rst_n, r_phase == P_SKIP, r_body != '0)
    `TMSP_ASSERT_IMPL(a_arr_count, i_clk, i_rst_n, r_phase == P_AINT, r_elem != '0)
    `TMSP_ASSERT_NEXT(a_comp_kept, i_clk, i_rst_n,
        acc_in && r_phase == P_HCOMP, r_comp == $past(i_data_byte))
endmodule
`default_nettype wire

// ===== rtl/tmsp_out_queue.sv =====
// ----------------------------------------------------------------------------
// tmsp_out_queue
// Token queue between the parse step and the output port.
// ----------------------------------------------------------------------------
`default_nettype none
module tmsp_out_queue
    import tmsp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [1:0]           i_push_count,
    input  t_token                    i_tok [MaxTokens],
    output logic                      o_room,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_token                    o_tok
);
    localparam int AW = $clog2(QDepth);
    t_token          r_mem [QDepth];
    logic [AW-1:0]   r_rd, r_wr;
    logic [AW:0]     r_cnt;
    logic            pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_tok   = r_mem[r_rd];
    // Room for a full set of tokens after this cycle's pop.
    assign o_room  = (r_cnt <= (AW+1)'(QDepth - MaxTokens)) || (pop &&
                     r_cnt == (AW+1)'(QDepth - MaxTokens + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (pop) r_rd <= r_rd + 1'b1;
            r_wr  <= r_wr + AW'(i_push_count);
            r_cnt <= r_cnt + (AW+1)'(i_push_count) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MaxTokens; k++) begin
            if (2'(k) < i_push_count) r_mem[r_wr + AW'(k)] <= i_tok[k];
        end
    end
endmodule
`default_nettype wire

// ===== test/typed_message_stream_parser_tb.sv =====
// ----------------------------------------------------------------------------
// typed_message_stream_parser_tb
// Streams whole messages, both well-formed and broken, into the parser, with
// random gaps on both sides after the first. A scoreboard predicts every token
// and compares the tokens that come out with its predictions, field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module typed_message_stream_parser_tb;
    import tmsp_pkg::*;

    localparam logic [3:0] TY_BUF = 4'd4, TY_PTR = 4'd5, TY_TIM = 4'd6;
    localparam logic [3:0] F_NEG = 4'd1, F_START = 4'd2, F_STOP = 4'd4, F_ARR = 4'd8;

    class token_scoreboard;
        t_token      pending[$];
        t_token      step_toks[$];
        int          bytes_seen;
        int          tokens_checked;
        t_phase      phase;
        bit [31:0]   body_left, field_cnt, elems_left;
        bit [63:0]   acc;
        bit [15:0]   tag_hist;
        bit [3:0]    obj_type, elem_type, flags;

        function void clear();
            phase = P_HLEN;
            body_left = 0; field_cnt = 0; elems_left = 0; acc = 0;
            tag_hist = 0; obj_type = 0; elem_type = 0; flags = 0;
        endfunction

        function void push_tok(t_kind k, bit [63:0] v, bit [3:0] ty, bit [7:0] aux,
                               bit arr, bit id);
            t_token t;
            if (step_toks.size() >= MaxTokens) return;
            t.kind = k; t.value = v; t.type_code = ty; t.aux_byte = aux;
            t.in_array = arr; t.is_identifier = id; t.last = 1'b0;
            step_toks.push_back(t);
        endfunction

        function void push_text(t_kind k, bit [63:0] v);
            bit [3:0] ty;
            ty = (obj_type == ID_MARK) ? T_STR : ((flags & F_ARR) != 0 ? elem_type : obj_type);
            push_tok(k, v, ty, 8'd0, (flags & F_ARR) != 0, obj_type == ID_MARK);
        endfunction

        function void idle();
            phase = P_HLEN; field_cnt = 0; acc = 0; flags = 0;
        endfunction

        function void abort(t_kind k, bit [3:0] ty);
            push_tok(k, {32'd0, body_left}, ty, 8'd0, 1'b0, 1'b0);
            idle();
            if (body_left != 0) phase = P_SKIP;
        endfunction

        function void open_field(t_phase ph, bit [31:0] need);
            if (body_left < need) begin
                abort(K_BADLEN, 4'd0);
                return;
            end
            phase = ph; field_cnt = 0; acc = 0;
        endfunction

        function void object_boundary();
            if (body_left == 0) begin
                push_tok(K_MEND, 64'd0, 4'd0, 8'd0, 1'b0, 1'b0);
                idle();
            end else begin
                open_field(P_TAG, 3);
            end
        endfunction

        function void open_element();
            open_field(elem_type == T_INT ? P_AINT : P_STRLEN, 4);
        endfunction

        function void element_finished();
            elems_left--;
            if (elems_left == 0) begin
                flags &= ~F_ARR;
                object_boundary();
            end else begin
                open_element();
            end
        endfunction

        function void text_finished();
            if ((flags & F_ARR) != 0) element_finished();
            else object_boundary();
        endfunction

        function int tag_index(bit [23:0] c);
            case (c)
                "chr": return 0;  "int": return 1;  "lon": return 2;  "str": return 3;
                "buf": return 4;  "ptr": return 5;  "tim": return 6;  "htb": return 7;
                "hda": return 8;  "inf": return 9;  "inl": return 10; "arr": return 11;
                default: return -1;
            endcase
        endfunction

        function void open_text(bit [31:0] len);
            push_text(K_TSTART, {32'd0, len});
            if (len == 0) begin
                push_text(K_TEND, 64'd0);
                text_finished();
            end else begin
                phase = P_TXT;
                field_cnt = len;
            end
        endfunction

        function void lon_digit(bit [7:0] b);
            bit        is_dig;
            bit [63:0] lim, d;
            is_dig = b >= "0" && b <= "9";
            if ((flags & F_STOP) != 0) return;
            if ((flags & F_START) == 0) begin
                if (b == " " || (b >= 9 && b <= 13)) return;
                if (b == "+") begin flags |= F_START; return; end
                if (b == "-") begin flags |= F_START | F_NEG; return; end
                if (!is_dig) begin flags |= F_STOP; return; end
                flags |= F_START;
            end
            if (!is_dig) begin
                flags |= F_STOP;
                return;
            end
            lim = (flags & F_NEG) != 0 ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            d = {56'd0, b - 8'd48};
            if (acc > (lim - d) / 10) acc = lim;
            else acc = acc * 10 + d;
        endfunction

        function void tag_complete(bit [23:0] c);
            int idx;
            idx = tag_index(c);
            if (phase == P_ATAG) begin
                if (idx < 0) begin abort(K_UNKTAG, 4'd0); return; end
                if (idx != T_INT && idx != T_STR) begin abort(K_BADELEM, idx[3:0]); return; end
                elem_type = idx[3:0];
                open_field(P_ACOUNT, 4);
                return;
            end
            if (idx < 0) begin abort(K_UNKTAG, 4'd0); return; end
            if (idx >= T_HTB && idx <= T_INL) begin abort(K_UNIMPL, idx[3:0]); return; end
            obj_type = idx[3:0];
            push_tok(K_TYPE, 64'd0, obj_type, 8'd0, 1'b0, 1'b0);
            case (obj_type)
                T_CHR: open_field(P_CHR, 1);
                T_INT: open_field(P_INT, 4);
                T_LON: open_field(P_LONLEN, 1);
                T_STR, TY_BUF: open_field(P_STRLEN, 4);
                TY_PTR, TY_TIM: open_field(P_SHORTLEN, 1);
                default: open_field(P_ATAG, 3);
            endcase
        endfunction

        function bit take_word(bit [7:0] b);
            acc = {32'd0, acc[23:0], b};
            field_cnt++;
            return field_cnt >= 4;
        endfunction

        function bit [63:0] word_sext();
            return {{32{acc[31]}}, acc[31:0]};
        endfunction

        function void body_beat(bit [7:0] b);
            bit [31:0] v;
            case (phase)
                P_TAG, P_ATAG: begin
                    if (field_cnt < 2) begin
                        tag_hist = {tag_hist[7:0], b};
                        field_cnt++;
                    end else begin
                        field_cnt = 0;
                        tag_complete({tag_hist, b});
                    end
                end
                P_CHR: begin
                    push_tok(K_CHR, {56'd0, b}, 4'd0, 8'd0, 1'b0, 1'b0);
                    object_boundary();
                end
                P_INT: if (take_word(b)) begin
                    push_tok(K_INT, word_sext(), T_INT, 8'd0, 1'b0, 1'b0);
                    object_boundary();
                end
                P_AINT: if (take_word(b)) begin
                    push_tok(K_INT, word_sext(), T_INT, 8'd0, 1'b1, 1'b0);
                    element_finished();
                end
                P_LONLEN: begin
                    if (b[7] || b > body_left) abort(K_BADLEN, 4'd0);
                    else if (b == 0) begin
                        push_tok(K_LON, 64'd0, T_LON, 8'd0, 1'b0, 1'b0);
                        object_boundary();
                    end else begin
                        phase = P_LONTXT; field_cnt = {24'd0, b}; acc = 0; flags = 0;
                    end
                end
                P_LONTXT: begin
                    lon_digit(b);
                    field_cnt--;
                    if (field_cnt == 0) begin
                        push_tok(K_LON, (flags & F_NEG) != 0 ? -acc : acc, T_LON, 8'd0,
                                 1'b0, 1'b0);
                        flags = 0;
                        object_boundary();
                    end
                end
                P_STRLEN: if (take_word(b)) begin
                    v = acc[31:0];
                    if (v == 32'hFFFF_FFFF) begin
                        push_text(K_TSTART, {64{1'b1}});
                        push_text(K_TEND, 64'd0);
                        text_finished();
                    end else if (v[31] || v > body_left) begin
                        abort(K_BADLEN, 4'd0);
                    end else begin
                        open_text(v);
                    end
                end
                P_SHORTLEN: begin
                    if (b[7] || b > body_left) abort(K_BADLEN, 4'd0);
                    else open_text({24'd0, b});
                end
                P_TXT: begin
                    push_text(K_TBYTE, {56'd0, b});
                    if (field_cnt > 0) field_cnt--;
                    if (field_cnt == 0) begin
                        push_text(K_TEND, 64'd0);
                        text_finished();
                    end
                end
                P_ACOUNT: if (take_word(b)) begin
                    v = acc[31:0];
                    if (v[31]) abort(K_BADLEN, 4'd0);
                    else begin
                        push_tok(K_ASTART, {32'd0, v}, elem_type, 8'd0, 1'b0, 1'b0);
                        if (v == 0) object_boundary();
                        else begin
                            elems_left = v;
                            flags |= F_ARR;
                            open_element();
                        end
                    end
                end
                P_SKIP: if (body_left == 0) idle();
                default: idle();
            endcase
        endfunction

        // Predicts the tokens of one accepted input beat and queues them.
        function void note_byte(bit [7:0] b);
            bit [31:0] total;
            step_toks.delete();
            bytes_seen++;
            if (phase == P_HLEN) begin
                if (take_word(b)) begin field_cnt = 0; phase = P_HCOMP; end
            end else if (phase == P_HCOMP) begin
                total = acc[31:0];
                body_left = total >= 5 ? total - 5 : 0;
                push_tok(K_HEADER, {32'd0, total}, 4'd0, b, 1'b0, 1'b0);
                acc = 0;
                if (b != 0) abort(K_COMPR, 4'd0);
                else begin
                    obj_type = ID_MARK;
                    flags = 0;
                    open_field(P_STRLEN, 4);
                end
            end else if (body_left == 0) begin
                idle();
                if (take_word(b)) begin field_cnt = 0; phase = P_HCOMP; end
            end else begin
                body_left--;
                body_beat(b);
            end
            if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
            foreach (step_toks[i]) pending.push_back(step_toks[i]);
        endfunction

        // Compares one output token with the oldest prediction.
        function bit check_token(t_token got, output string msg);
            t_token want;
            tokens_checked++;
            if (pending.size() == 0) begin
                msg = $sformatf("unexpected token kind %0d value %0d", got.kind, got.value);
                return 1'b0;
            end
            want = pending.pop_front();
            if (got !== want) begin
                msg = $sformatf({"token %0d: got k%0d v%0h t%0d a%0h arr%0b id%0b l%0b,",
                    " want k%0d v%0h t%0d a%0h arr%0b id%0b l%0b"}, tokens_checked,
                    got.kind, got.value, got.type_code, got.aux_byte, got.in_array,
                    got.is_identifier, got.last, want.kind, want.value, want.type_code,
                    want.aux_byte, want.in_array, want.is_identifier, want.last);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    logic              i_clk, i_rst_n, i_valid, i_ready;
    logic [7:0]        i_data_byte;
    logic              o_ready, o_valid, o_in_array, o_is_identifier, o_last;
    logic [3:0]        o_kind, o_type_code;
    logic signed [63:0] o_value;
    logic [7:0]        o_aux_byte;

    token_scoreboard   sb;
    int                error_count;
    bit                gaps_on;
    bit [7:0]          body[$];

    typed_message_stream_parser u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_value(o_value), .o_type_code(o_type_code),
        .o_aux_byte(o_aux_byte), .o_in_array(o_in_array),
        .o_is_identifier(o_is_identifier), .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string msg);
        error_count++;
        $display("MISMATCH: %s", msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !gaps_on || $urandom_range(99) >= 13;
    end

    always @(posedge i_clk) begin
        t_token got;
        string  msg;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_kind, o_value, o_type_code, o_aux_byte, o_in_array,
                    o_is_identifier, o_last};
            if (!sb.check_token(got, msg)) report(msg);
        end
    end

    task automatic send_byte(input bit [7:0] b);
        while (gaps_on && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    function automatic void put32(bit [31:0] v);
        body.push_back(v[31:24]); body.push_back(v[23:16]);
        body.push_back(v[15:8]);  body.push_back(v[7:0]);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
    endfunction

    function automatic void put_text32(string s);
        put32(s.len());
        put_str(s);
    endfunction

    function automatic void put_short(string tag, string s);
        put_str(tag);
        body.push_back(8'(s.len()));
        put_str(s);
    endfunction

    function automatic string rand_text(int n, bit numeric);
        string s, pool;
        s = "";
        pool = numeric ? "  +-0123456789012345678x\t" : "abcXYZ 09~";
        for (int i = 0; i < n; i++)
            s = {s, string'(pool[$urandom_range(pool.len() - 1)])};
        return s;
    endfunction

    // Appends one well-formed object with random content.
    function automatic void add_good_object();
        int n;
        n = $urandom_range(3);
        case ($urandom_range(8))
            0: begin put_str("chr"); body.push_back(8'($urandom_range(255))); end
            1: begin put_str("int"); put32($urandom); end
            2: put_short("lon", rand_text($urandom_range(20), 1'b1));
            3: begin put_str("str"); put_text32(rand_text($urandom_range(5), 1'b0)); end
            4: begin
                put_str("buf");
                if ($urandom_range(3) == 0) put32(32'hFFFF_FFFF);
                else put_text32(rand_text($urandom_range(4), 1'b0));
            end
            5: put_short("ptr", rand_text($urandom_range(4), 1'b0));
            6: put_short("tim", rand_text($urandom_range(4), 1'b1));
            7: begin
                put_str("arrint"); put32(n);
                repeat (n) put32($urandom);
            end
            default: begin
                put_str("arrstr"); put32(n);
                repeat (n) put_text32(rand_text($urandom_range(3), 1'b0));
            end
        endcase
    endfunction

    // Appends one object that must end the message with an error token.
    function automatic void add_bad_object();
        case ($urandom_range(7))
            0: put_str("xyz");
            1: begin put_str("inl"); put32(0); end
            2: put_str("hda");
            3: begin put_str("arrlon"); put32(1); end
            4: begin put_str("str"); put32(32'hFFFF_FFFE); end
            5: begin put_str("buf"); put32(32'd60); put_str("ab"); end
            6: begin put_str("lon"); body.push_back(8'h80 | 8'($urandom_range(127))); end
            default: begin put_str("arrint"); put32(32'h8000_0000 | $urandom); end
        endcase
    endfunction

    task automatic send_message(input bit [7:0] comp);
        bit [31:0] total;
        bit [7:0]  data[$];
        total = body.size() + 5;
        data = {total[31:24], total[23:16], total[15:8], total[7:0], comp, body};
        body.delete();
        foreach (data[i]) send_byte(data[i]);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        sb.clear();
        error_count = 0;
        gaps_on = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = 8'd0;
        i_ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every object type and the extremes of each field, sent with
        // no idle cycles on either side.
        gaps_on = 1'b0;
        put_text32("id");
        put_str("chr"); body.push_back(8'hFF);
        put_str("int"); put32(32'h8000_0000);
        put_short("lon", " \t-9223372036854775809");
        put_short("lon", "+9999999999999999999");
        put_short("lon", "");
        put_short("lon", "x12");
        put_str("str"); put_text32("");
        put_str("buf"); put32(32'hFFFF_FFFF);
        put_short("ptr", "");
        put_short("tim", "12");
        put_str("arrint"); put32(2); put32(32'hFFFF_FFFF); put32(5);
        put_str("arrstr"); put32(1); put_text32("z");
        send_message(8'd0);
        gaps_on = 1'b1;
        // A body too short for the identifier length, then a compressed body.
        put32(0);
        body.pop_back();
        send_message(8'd0);
        put_str("abc");
        send_message(8'h81);
        // Null identifier and a tag that runs past the end of the body.
        put32(32'hFFFF_FFFF); put_str("ch");
        send_message(8'd0);
        put_text32("e");
        add_bad_object();
        put_str("pad");
        send_message(8'd0);

        i_valid <= 1'b0;
        wait_drained();

        // Random messages, mostly well formed.
        while (sb.bytes_seen < 195) begin
            if ($urandom_range(3) == 0) put32(32'hFFFF_FFFF);
            else put_text32(rand_text($urandom_range(3), 1'b0));
            repeat ($urandom_range(4)) add_good_object();
            if ($urandom_range(4) == 0) add_bad_object();
            send_message($urandom_range(9) == 0 ? 8'($urandom_range(1, 255)) : 8'd0);
        end
        i_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d stream bytes in typed messages of every object kind,", sb.bytes_seen);
        $display("including error, compressed and short-length cases; %0d tokens checked.",
                 sb.tokens_checked);
        if (error_count == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
